### rtl/point_segment_distance_3d_assert.svh
// Assertion macros shared by the checker of the point-to-segment block.
`ifndef POINT_SEGMENT_DISTANCE_3D_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_3D_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define PSD_AST_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point_segment_distance_3d check failed");

// Next-cycle implication, ignored while reset is high.
`define PSD_AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point_segment_distance_3d check failed");

// Next-cycle implication that also holds across reset.
`define PSD_AST_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("point_segment_distance_3d reset check failed");

`endif

### rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants of the point-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;
  localparam int AXES = 3;
endpackage

### rtl/psd_in_if.sv
// ----------------------------------------------------------------------------
// psd_in_if
// Input channel: segment start, segment end and query point.
// ----------------------------------------------------------------------------
interface psd_in_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic signed [COORD_BITS-1:0] query_z;

  modport source (
    output valid, start_x, start_y, start_z, end_x, end_y, end_z,
           query_x, query_y, query_z,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
           query_x, query_y, query_z,
    output ready
  );
endinterface

### rtl/psd_out_if.sv
// ----------------------------------------------------------------------------
// psd_out_if
// Output channel: distance from the query point to the segment.
// ----------------------------------------------------------------------------
interface psd_out_if #(
  parameter int DIST_BITS = 34
);
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

### rtl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Differences, per-axis products and the squared length and dot product.
// ----------------------------------------------------------------------------
module psd_front #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [COORD_BITS-1:0]        s_pt [psd_pkg::AXES],
  input  logic [COORD_BITS-1:0]        e_pt [psd_pkg::AXES],
  input  logic [COORD_BITS-1:0]        q_pt [psd_pkg::AXES],
  output logic                         out_valid,
  output logic signed [2*COORD_BITS+3:0] l2,
  output logic signed [2*COORD_BITS+3:0] dot,
  output logic signed [COORD_BITS:0]   d_out [psd_pkg::AXES],
  output logic signed [COORD_BITS:0]   e_out [psd_pkg::AXES]
);
  import psd_pkg::*;

  localparam int PW = 2 * COORD_BITS + 2;
  localparam int SW = 2 * COORD_BITS + 4;

  logic                     v1, v2;
  logic signed [COORD_BITS:0] d1 [AXES];
  logic signed [COORD_BITS:0] e1 [AXES];
  logic signed [COORD_BITS:0] d2 [AXES];
  logic signed [COORD_BITS:0] e2 [AXES];
  logic signed [PW-1:0]     dd2 [AXES];
  logic signed [PW-1:0]     de2 [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        d1[i]    <= $signed({e_pt[i][COORD_BITS-1], e_pt[i]})
                  - $signed({s_pt[i][COORD_BITS-1], s_pt[i]});
        e1[i]    <= $signed({q_pt[i][COORD_BITS-1], q_pt[i]})
                  - $signed({s_pt[i][COORD_BITS-1], s_pt[i]});
        dd2[i]   <= d1[i] * d1[i];
        de2[i]   <= d1[i] * e1[i];
        d2[i]    <= d1[i];
        e2[i]    <= e1[i];
        d_out[i] <= d2[i];
        e_out[i] <= e2[i];
      end
      l2  <= $signed({{2{dd2[0][PW-1]}}, dd2[0]}) + $signed({{2{dd2[1][PW-1]}}, dd2[1]})
           + $signed({{2{dd2[2][PW-1]}}, dd2[2]});
      dot <= $signed({{2{de2[0][PW-1]}}, de2[0]}) + $signed({{2{de2[1][PW-1]}}, de2[1]})
           + $signed({{2{de2[2][PW-1]}}, de2[2]});
    end
  end

  logic unused_sw;
  assign unused_sw = (SW == PW + 2) ? 1'b0 : 1'b1;
endmodule

### rtl/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// Projection parameter: clamped quotient, one fraction bit per stage after the load stage.
// ----------------------------------------------------------------------------
module psd_div #(
  parameter int FRAC_BITS = 16,
  parameter int SW        = 68,
  parameter int SIDE_W    = 198
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [SW-1:0] l2,
  input  logic signed [SW-1:0] dot,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   t,
  output logic [SIDE_W-1:0]    side_out
);
  localparam int RW = SW + 1;

  logic              v    [FRAC_BITS+1];
  logic              zf   [FRAC_BITS+1];
  logic              of   [FRAC_BITS+1];
  logic [RW-1:0]     r    [FRAC_BITS+1];
  logic [RW-1:0]     den  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q [FRAC_BITS+1];
  logic [SIDE_W-1:0] side [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      zf[0]   <= (dot <= 0);
      of[0]   <= (dot >= l2);
      r[0]    <= {1'b0, dot};
      den[0]  <= {1'b0, l2};
      q[0]    <= '0;
      side[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [RW-1:0] sh;
    logic          ge;
    always_comb begin
      sh = {r[k-1][RW-2:0], 1'b0};
      ge = (sh >= den[k-1]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
      if (en) begin
        r[k]    <= ge ? sh - den[k-1] : sh;
        q[k]    <= {q[k-1][FRAC_BITS-2:0], ge};
        zf[k]   <= zf[k-1];
        of[k]   <= of[k-1];
        den[k]  <= den[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  always_comb begin
    if (zf[FRAC_BITS]) begin
      t = '0;
    end else if (of[FRAC_BITS]) begin
      t = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      t = {1'b0, q[FRAC_BITS]};
    end
  end

  assign out_valid = v[FRAC_BITS];
  assign side_out  = side[FRAC_BITS];
endmodule

### rtl/psd_sqrt.sv
// ----------------------------------------------------------------------------
// psd_sqrt
// Truncated integer square root, one result bit per stage after the load stage.
// ----------------------------------------------------------------------------
module psd_sqrt #(
  parameter int NW = 70
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     n_in,
  output logic              out_valid,
  output logic [NW/2-1:0]   root_out
);
  localparam int QW = NW / 2;

  logic            v    [QW+1];
  logic [QW+1:0]   rem  [QW+1];
  logic [QW-1:0]   root [QW+1];
  logic [NW-1:0]   n    [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      rem[0]  <= '0;
      root[0] <= '0;
      n[0]    <= n_in;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [QW+3:0] rem2, trial, diff;
    logic          ge;
    always_comb begin
      rem2  = {rem[k-1], n[k-1][NW-1:NW-2]};
      trial = {2'b00, root[k-1], 2'b01};
      ge    = (rem2 >= trial);
      diff  = rem2 - trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
      if (en) begin
        rem[k]  <= ge ? diff[QW+1:0] : rem2[QW+1:0];
        root[k] <= {root[k-1][QW-2:0], ge};
        n[k]    <= {n[k-1][NW-3:0], 2'b00};
      end
    end
  end

  assign out_valid = v[QW];
  assign root_out  = root[QW];
endmodule

### rtl/point_segment_distance_3d.sv
// ----------------------------------------------------------------------------
// point_segment_distance_3d
// Distance from a 3D point to a 3D segment, fully pipelined fixed point.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  points    in   start_x/y/z, end_x/y/z, query_x/y/z (signed Q16.16)
//  result    out  distance (unsigned Q18.16, truncated)
//
// One item enters per cycle unless the output stalls. The pipeline has
// three front-end stages, FRAC_BITS + 1 quotient stages (a load stage, then
// one fraction bit each), three residual stages and COORD_BITS + 4
// square-root stages (a load stage, then one root bit each).
// Reset is synchronous and clears only the valid bits of every stage.
// The whole pipeline advances together; it freezes when the final stage holds
// an item that the sink does not take, so a stall loses and repeats nothing.
// ----------------------------------------------------------------------------
module point_segment_distance_3d #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 32
) (
  input  logic   clk,
  input  logic   rst,
  psd_in_if.sink points,
  psd_out_if.source result
);
  import psd_pkg::*;

  localparam int DW     = COORD_BITS + 1;        // difference width
  localparam int SW     = 2 * COORD_BITS + 4;    // squared length and dot
  localparam int SIDE_W = 2 * AXES * DW;
  localparam int PRW    = FRAC_BITS + DW + 1;    // t times difference
  localparam int RSW    = COORD_BITS + 2;        // residual
  localparam int SQW    = 2 * RSW;               // squared residual
  localparam int NW     = SQW + 2;               // sum of three squares
  localparam int QW     = NW / 2;
  localparam int DISTW  = COORD_BITS + 2;

  // Global advance: the last stage is the output register.
  logic en;
  assign en           = !result.valid || result.ready;
  assign points.ready = en;

  logic [COORD_BITS-1:0] s_pt [AXES];
  logic [COORD_BITS-1:0] e_pt [AXES];
  logic [COORD_BITS-1:0] q_pt [AXES];

  assign s_pt[0] = points.start_x;
  assign s_pt[1] = points.start_y;
  assign s_pt[2] = points.start_z;
  assign e_pt[0] = points.end_x;
  assign e_pt[1] = points.end_y;
  assign e_pt[2] = points.end_z;
  assign q_pt[0] = points.query_x;
  assign q_pt[1] = points.query_y;
  assign q_pt[2] = points.query_z;

  // Front end: D = E - S, R = P - S, then |D|^2 and R . D.
  logic                 f_valid;
  logic signed [SW-1:0] f_l2, f_dot;
  logic signed [DW-1:0] f_d [AXES];
  logic signed [DW-1:0] f_e [AXES];

  psd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (points.valid && points.ready),
    .s_pt      (s_pt),
    .e_pt      (e_pt),
    .q_pt      (q_pt),
    .out_valid (f_valid),
    .l2        (f_l2),
    .dot       (f_dot),
    .d_out     (f_d),
    .e_out     (f_e)
  );

  // The differences ride alongside the quotient stages.
  logic [SIDE_W-1:0] side_in, side_out;
  assign side_in = {f_d[2], f_d[1], f_d[0], f_e[2], f_e[1], f_e[0]};

  logic                 q_valid;
  logic [FRAC_BITS:0]   t;

  psd_div #(.FRAC_BITS(FRAC_BITS), .SW(SW), .SIDE_W(SIDE_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .l2        (f_l2),
    .dot       (f_dot),
    .side_in   (side_in),
    .out_valid (q_valid),
    .t         (t),
    .side_out  (side_out)
  );

  logic signed [DW-1:0] q_d [AXES];
  logic signed [DW-1:0] q_e [AXES];
  for (genvar i = 0; i < AXES; i++) begin : g_unpack
    assign q_d[i] = side_out[(AXES+i)*DW +: DW];
    assign q_e[i] = side_out[i*DW +: DW];
  end

  // Residual stages: T * D, then R - floor(T * D / 2^F) squared, then summed.
  // Taking the upper bits of the signed product gives the floor directly.
  logic                  m1_valid, m2_valid, m3_valid;
  logic signed [PRW-1:0] m1_p [AXES];
  logic signed [DW-1:0]  m1_e [AXES];
  logic signed [RSW-1:0] res  [AXES];
  logic signed [SQW-1:0] m2_sq [AXES];
  logic [NW-1:0]         m3_sum;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      res[i] = $signed({m1_e[i][DW-1], m1_e[i]})
             - $signed(m1_p[i][PRW-1 -: RSW] >>> 0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= q_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        m1_p[i]  <= $signed({1'b0, t}) * q_d[i];
        m1_e[i]  <= q_e[i];
        m2_sq[i] <= res[i] * res[i];
      end
      m3_sum <= {2'b00, m2_sq[0]} + {2'b00, m2_sq[1]} + {2'b00, m2_sq[2]};
    end
  end

  logic          r_valid;
  logic [QW-1:0] root;

  psd_sqrt #(.NW(NW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m3_valid),
    .n_in      (m3_sum),
    .out_valid (r_valid),
    .root_out  (root)
  );

  assign result.valid    = r_valid;
  assign result.distance = root[DISTW-1:0];
endmodule

### rtl/psd_check.sv
// ----------------------------------------------------------------------------
// psd_check
// Port-level checks of the point-to-segment distance block.
// ----------------------------------------------------------------------------
`include "point_segment_distance_3d_assert.svh"

module psd_check #(
  parameter int DIST_BITS = 34
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 points_valid,
  input logic                 points_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic [DIST_BITS-1:0] distance
);
  // A waiting item holds its value until taken.
  `PSD_AST_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(distance))
  // Input side is open exactly when the output register can move.
  `PSD_AST_NOW(a_ready, 1'b1, points_ready == (!result_valid || result_ready))
  // Reset empties the pipeline.
  `PSD_AST_RST(a_reset, rst, !result_valid)

  logic unused_in;
  assign unused_in = points_valid;
endmodule

bind point_segment_distance_3d psd_check #(.DIST_BITS(COORD_BITS + 2)) u_psd_check (
  .clk          (clk),
  .rst          (rst),
  .points_valid (points.valid),
  .points_ready (points.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .distance     (result.distance)
);

### dv/psd_distance_checker.sv
// ----------------------------------------------------------------------------
// psd_distance_checker
// Watches both channels of the point-to-segment block, works out the
// distance for every accepted item and compares it with each result.
// ----------------------------------------------------------------------------
module psd_distance_checker (
  input  logic clk,
  input  logic rst,
  psd_in_if    points,
  psd_out_if   result,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   n_before,
  output int   n_past,
  output int   n_inside
);
  localparam int FRAC = 16;

  typedef logic signed [31:0]  coord_t;
  typedef logic signed [127:0] wide_t;

  logic [33:0] distance_q[$];
  int          proj_kind;

  function automatic wide_t widen(input coord_t v);
    return $signed({{96{v[31]}}, v});
  endfunction

  // Exact distance; proj_kind records where the projection fell.
  function automatic logic [33:0] segment_distance(input coord_t c[9]);
    wide_t        d[3], e[3];
    wide_t        l2, dot, sq, res, tw;
    logic [127:0] root, cand;
    logic [FRAC:0] t;
    l2 = '0;
    dot = '0;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = widen(c[3+i]) - widen(c[i]);
      e[i] = widen(c[6+i]) - widen(c[i]);
      l2 += d[i] * d[i];
      dot += d[i] * e[i];
    end
    if (dot <= 0) begin
      t = '0;
      proj_kind = 0;
    end else if (dot >= l2) begin
      t = {1'b1, {FRAC{1'b0}}};
      proj_kind = 1;
    end else begin
      t = (FRAC+1)'((dot <<< FRAC) / l2);
      proj_kind = 2;
    end
    tw = $signed({{(127-FRAC){1'b0}}, t});
    for (int i = 0; i < 3; i++) begin
      res = e[i] - ((d[i] * tw) >>> FRAC);
      sq += res * res;
    end
    root = '0;
    for (int b = 40; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= sq) root = cand;
    end
    return root[33:0];
  endfunction

  always @(posedge clk) begin
    coord_t      c[9];
    logic [33:0] want;
    if (!rst) begin
      if (points.valid && points.ready) begin
        c = '{points.start_x, points.start_y, points.start_z,
              points.end_x, points.end_y, points.end_z,
              points.query_x, points.query_y, points.query_z};
        distance_q.insert(distance_q.size(), segment_distance(c));
        case (proj_kind)
          0: n_before++;
          1: n_past++;
          default: n_inside++;
        endcase
      end
      if (result.valid && result.ready) begin
        checked++;
        if (distance_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result distance=%0d", result.distance);
        end else begin
          want = distance_q.pop_front();
          if (want !== result.distance) begin
            errors++;
            if (errors <= 10)
              $display("distance mismatch on result %0d: expected %0d, got %0d",
                       checked, want, result.distance);
          end
        end
      end
    end
    pending = distance_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
    n_before = 0;
    n_past = 0;
    n_inside = 0;
  end
endmodule

### dv/point_segment_distance_3d_tb.sv
// ----------------------------------------------------------------------------
// point_segment_distance_3d_tb
// Drives directed and random segment/point items into the distance block
// with random gaps and back-pressure; a checker beside it predicts results.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_tb;
  typedef logic signed [31:0] coord_t;

  localparam int N_RANDOM = 1250;
  localparam int LATENCY  = 59;

  logic clk;
  logic rst;

  psd_in_if  #(.COORD_BITS(32)) points ();
  psd_out_if #(.DIST_BITS(34))  result ();

  int errors, pending, checked, n_before, n_past, n_inside;
  int sent;
  bit sending_done;
  // When set, both sides run without idle cycles.
  bit no_idle;
  // Long receiver hold-off, raised by its own process below.
  bit hold_off;
  int rx_wait;

  point_segment_distance_3d u_dut (
    .clk    (clk),
    .rst    (rst),
    .points (points),
    .result (result)
  );

  psd_distance_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .points   (points),
    .result   (result),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked),
    .n_before (n_before),
    .n_past   (n_past),
    .n_inside (n_inside)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one item and hold it until the block takes it. Valid stays high on
  // return so that a back-to-back item does not drop it for a cycle.
  task automatic send_item(input coord_t c[9]);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      points.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    points.valid   <= 1'b1;
    points.start_x <= c[0];
    points.start_y <= c[1];
    points.start_z <= c[2];
    points.end_x   <= c[3];
    points.end_y   <= c[4];
    points.end_z   <= c[5];
    points.query_x <= c[6];
    points.query_y <= c[7];
    points.query_z <= c[8];
    do @(posedge clk); while (!points.ready);
    sent++;
  endtask

  // A coordinate of a chosen scale: small ones keep the projection inside the
  // segment often, full-range ones exercise every bit.
  function automatic coord_t pick(input int scale);
    case (scale)
      0: return $signed($urandom_range(0, 64)) - 32;
      1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: after each accepted result it waits a random number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      rx_wait = $urandom_range(0, 16);
    end else if (result.valid && result.ready) begin
      rx_wait = no_idle ? 0 : $urandom_range(0, 16);
      result.ready <= (rx_wait == 0) && !hold_off;
    end else if (hold_off) begin
      result.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  // Hold the output off long enough that the pipeline fills and the input
  // stalls while the sender keeps offering items.
  initial begin
    hold_off = 1'b0;
    wait (sent >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    coord_t c[9];
    coord_t mn, mx;
    int kind, scale;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    points.valid <= 1'b0;
    points.start_x <= '0;
    points.start_y <= '0;
    points.start_z <= '0;
    points.end_x <= '0;
    points.end_y <= '0;
    points.end_z <= '0;
    points.query_x <= '0;
    points.query_y <= '0;
    points.query_z <= '0;
    sent = 0;
    sending_done = 0;
    no_idle = 1'b0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: everything at zero, a zero-length segment, projections
    // before the start, past the end and in the middle, and the extremes.
    send_item('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_item('{5, -7, 9, 5, -7, 9, 100, 200, -300});
    send_item('{mn, mn, mn, mn, mn, mn, mx, mx, mx});
    send_item('{mx, mx, mx, mx, mx, mx, mn, mn, mn});
    send_item('{0, 0, 0, 32'sh10000, 0, 0, -32'sh10000, 32'sh5000, 0});
    send_item('{0, 0, 0, 32'sh10000, 0, 0, 32'sh30000, -32'sh5000, 7});
    send_item('{0, 0, 0, 32'sh10000, 0, 0, 32'sh8000, 32'sh10000, 0});
    send_item('{0, 0, 0, 3, 0, 0, 1, 5, 0});
    send_item('{mn, mn, mn, mx, mx, mx, 0, 0, 0});
    send_item('{mn, mn, mn, mx, mx, mx, mx, mn, mx});
    send_item('{mx, mn, mx, mn, mx, mn, mn, mn, mn});
    send_item('{mn, 0, 0, mx, 0, 0, mx, mx, mx});
    send_item('{mn, mx, mn, mx, mn, mx, mx, mx, mn});
    send_item('{-1, -1, -1, 1, 1, 1, 0, 0, 0});
    send_item('{-1, -1, -1, -1, -1, -1, mn, mx, mn});
    send_item('{0, 0, 0, 0, 0, 1, 0, 0, 1});
    send_item('{mx, mx, mx, mn, mn, mn, mx, mx, mx});
    send_item('{0, 0, 0, 7, 11, 13, 7, 11, 13});

    for (int n = 0; n < N_RANDOM; n++) begin
      // Every 150 items the idling style is drawn anew, with bursts one time in three.
      if (n % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
      scale = $urandom_range(0, 2);
      for (int k = 0; k < 9; k++) c[k] = pick(scale);
      kind = $urandom_range(0, 9);
      case (kind)
        // Zero-length segment.
        0: for (int k = 0; k < 3; k++) c[3+k] = c[k];
        // Query on or near one of the ends.
        1: for (int k = 0; k < 3; k++) c[6+k] = c[3+k] + pick(0);
        2: for (int k = 0; k < 3; k++) c[6+k] = c[k] + pick(0);
        // Query near the midpoint, so the projection falls inside.
        3: for (int k = 0; k < 3; k++)
             c[6+k] = coord_t'((longint'(c[k]) + longint'(c[3+k])) >>> 1) + pick(0);
        default: ;
      endcase
      send_item(c);
    end
    points.valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    wait (pending == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("%0d items sent, %0d results checked; projections before start %0d,",
             sent, checked, n_before);
    $display("past end %0d, inside segment %0d, with idle gaps and a long output stall.",
             n_past, n_inside);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Well above the slowest correct run: every item and result waiting out
  // the longest gap on both sides, plus the pipeline depth and the hold-off.
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", pending);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
